/* rtl/assert_macros.svh */
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/mvsm_pkg.sv */
// Package with constants and types for the multi-voice sample mixer.
`default_nettype none
package mvsm_pkg;
    localparam int VOICES            = 32;
    localparam int ONESHOT_VOICES    = 19;
    localparam int SAMPLES_PER_VOICE = 4096;
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ADDR_W  = $clog2(SAMPLES_PER_VOICE);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int WAVE_DEPTH = VOICES * SAMPLES_PER_VOICE;
    localparam int WAVE_AW    = VOICE_W + ADDR_W;
    localparam int VOICE_STATE_W = LEN_W + ADDR_W;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_TRIGGER = 3'd1;
    localparam logic [2:0] CMD_HALT    = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;
    localparam logic [2:0] CMD_LENGTH  = 3'd5;

    localparam logic REG_VOLUME  = 1'b0;
    localparam logic REG_EFFECTS = 1'b1;

    localparam logic [3:0] VOLUME_MAX   = 4'd10;
    localparam logic [3:0] VOLUME_RESET = 4'd8;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_MIX   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_ACC   = 5'b10000
    } state_t;
endpackage
`default_nettype wire

/* rtl/mvsm_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/multi_voice_sample_mixer_top.sv */
// Top level of the multi-voice sample mixer.
// A tick walks the voices one at a time through four states per voice (state read,
// waveform read, scale, accumulate) and then presents its beat; a new command is
// taken only when the mixer is idle and the previous beat has been taken.
// Reset clears control, valid bits and play flags at once; no clearing pass
// is needed, since valid bits mark loaded voices.
`default_nettype none
module multi_voice_sample_mixer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [3:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    command,
    input  wire logic [4:0]                    voice,
    input  wire logic [31:0]                   trigger_mask,
    input  wire logic [11:0]                   sample_address,
    input  wire logic signed [15:0]            sample_value,
    input  wire logic [12:0]                   length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [15:0]                 mixed_sample
);
    import mvsm_pkg::*;
    `include "assert_macros.svh"

    // Control registers.
    state_t                state_reg, state_next;
    logic [3:0]            volume_reg;
    logic                  effects_reg;
    logic [VOICES-1:0]     playing_reg;
    logic [VOICES-1:0]     loaded_reg;     // length entry has been written
    logic [VOICES-1:0]     rewind_reg;     // cursor reads as zero
    logic [VOICE_W-1:0]    idx_reg;
    logic signed [16:0]    sum_reg;
    logic signed [20:0]    prod_reg;
    logic                  hit_reg;
    logic                  out_valid_reg;
    logic signed [15:0]    out_reg;

    // The per-voice length and cursor live in one small memory; the
    // waveforms live in the large memory.
    logic                      vs_we;
    logic [VOICE_W-1:0]        vs_waddr;
    logic [VOICE_STATE_W-1:0]  vs_wdata, vs_rdata;
    logic                      wv_we;
    logic [WAVE_AW-1:0]        wv_waddr, wv_raddr;
    logic signed [15:0]        wv_rdata;

    logic [LEN_W-1:0]   cur_len;
    logic [ADDR_W-1:0]  cur_pos, pos_use, pos_inc;
    logic               oneshot, active, wrap;
    logic [LEN_W-1:0]   len_clip;
    logic               accept;
    logic signed [22:0] scaled;
    logic signed [17:0] sum_add;
    logic signed [16:0] sum_sat;

    mvsm_ram #(.WIDTH(VOICE_STATE_W), .DEPTH(VOICES)) u_voice_ram (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
        .raddr(idx_reg), .rdata(vs_rdata)
    );

    mvsm_ram #(.WIDTH(16), .DEPTH(WAVE_DEPTH)) u_wave_ram (
        .clk(clk), .we(wv_we), .waddr(wv_waddr), .wdata(sample_value),
        .raddr(wv_raddr), .rdata(wv_rdata)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_reg;

    assign cur_len = loaded_reg[idx_reg] ? vs_rdata[VOICE_STATE_W-1:ADDR_W] : '0;
    assign cur_pos = rewind_reg[idx_reg] ? '0 : vs_rdata[ADDR_W-1:0];
    assign oneshot = ({1'b0, idx_reg} < (VOICE_W+1)'(ONESHOT_VOICES));
    assign active  = (cur_len != '0)
                     && (playing_reg[idx_reg] || (oneshot && cur_pos != '0));
    assign pos_use = ({1'b0, cur_pos} >= cur_len) ? '0 : cur_pos;
    assign pos_inc = pos_use + 1'b1;
    assign wrap    = ({1'b0, pos_use} + 1'b1) >= cur_len;
    assign len_clip = (length > LEN_W'(SAMPLES_PER_VOICE))
                      ? LEN_W'(SAMPLES_PER_VOICE) : length;

    assign wv_raddr = {idx_reg, pos_use};
    assign wv_we    = accept && command == CMD_WRITE;
    assign wv_waddr = {voice[VOICE_W-1:0], sample_address[ADDR_W-1:0]};

    // Truncating divide by ten: multiply by the reciprocal, then correct.
    always_comb
    begin
        logic signed [20:0] a;
        logic [20:0]        m;
        logic [41:0]        q;
        logic [20:0]        r;
        a = prod_reg;
        m = a[20] ? 21'(-a) : 21'(a);
        q = 42'(m) * 42'd209716;
        r = 21'(q >> 21);
        if (21'(r * 21'd10) > m)
        begin
            r = r - 1'b1;
        end
        scaled = a[20] ? -23'(r) : 23'(r);
    end

    assign sum_add = 18'(sum_reg) + 18'(scaled);
    assign sum_sat = (sum_add > 18'sd32767) ? 17'sd32767 :
                     (sum_add < -18'sd32768) ? -17'sd32768 : 17'(sum_add);

    // Per voice: READ addresses the voice state, MIX sees it and addresses the
    // waveform, SCALE sees the sample and forms the product, ACC adds it in.
    always_comb
    begin
        state_next = state_reg;
        vs_we      = 1'b0;
        vs_waddr   = idx_reg;
        vs_wdata   = {cur_len, wrap ? {ADDR_W{1'b0}} : pos_inc};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_TICK)
                begin
                    state_next = ST_READ;
                end
                if (accept && command == CMD_LENGTH
                    && {1'b0, voice} < 6'(VOICES))
                begin
                    vs_we    = 1'b1;
                    vs_waddr = voice[VOICE_W-1:0];
                    vs_wdata = {len_clip, {ADDR_W{1'b0}}};
                end
            end
            ST_READ:  state_next = ST_MIX;
            ST_MIX:
            begin
                vs_we      = active;
                state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_ACC;
            ST_ACC:
            begin
                state_next = (idx_reg == VOICE_W'(VOICES-1)) ? ST_IDLE : ST_READ;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            volume_reg    <= VOLUME_RESET;
            effects_reg   <= 1'b1;
            playing_reg   <= '0;
            loaded_reg    <= '0;
            rewind_reg    <= '1;
            idx_reg       <= '0;
            sum_reg       <= '0;
            prod_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_VOLUME)
                begin
                    volume_reg <= (cfg_data > VOLUME_MAX) ? VOLUME_MAX : cfg_data;
                end
                else
                begin
                    effects_reg <= cfg_data[0];
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                case (command)
                    CMD_TICK:
                    begin
                        idx_reg <= '0;
                        sum_reg <= '0;
                    end
                    CMD_TRIGGER:
                    begin
                        if (volume_reg != '0 && effects_reg)
                        begin
                            for (int i = 0; i < VOICES; i++)
                            begin
                                if (i < 32 && trigger_mask[i % 32])
                                begin
                                    playing_reg[i] <= 1'b1;
                                    if (i < ONESHOT_VOICES) rewind_reg[i] <= 1'b1;
                                end
                                else if (i >= ONESHOT_VOICES)
                                begin
                                    playing_reg[i] <= 1'b0;
                                end
                            end
                        end
                    end
                    CMD_HALT: playing_reg <= '0;
                    CMD_STOP:
                    begin
                        playing_reg <= '0;
                        rewind_reg  <= '1;
                    end
                    CMD_LENGTH:
                    begin
                        if ({1'b0, voice} < 6'(VOICES))
                        begin
                            loaded_reg[voice[VOICE_W-1:0]]  <= 1'b1;
                            playing_reg[voice[VOICE_W-1:0]] <= 1'b0;
                            rewind_reg[voice[VOICE_W-1:0]]  <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_MIX)
            begin
                hit_reg <= active;
                if (active)
                begin
                    rewind_reg[idx_reg] <= 1'b0;
                    if (wrap && oneshot) playing_reg[idx_reg] <= 1'b0;
                end
            end
            if (state_reg == ST_SCALE)
            begin
                prod_reg <= 21'(wv_rdata) * $signed({1'b0, volume_reg});
            end
            if (state_reg == ST_ACC)
            begin
                if (hit_reg) sum_reg <= sum_sat;
                if (idx_reg == VOICE_W'(VOICES-1))
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= hit_reg ? 16'(sum_sat) : 16'(sum_reg);
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    `ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `ASSERT_IMPL(a_sum_range, clk, rst_n, 1'b1,
        sum_reg <= 17'sd32767 && sum_reg >= -17'sd32768)
    `ASSERT_NEXT(a_tick_start, clk, rst_n, accept && command == CMD_TICK,
        state_reg == ST_READ)
endmodule
`default_nettype wire

/* tb/mix_checker.sv */
`timescale 1ns / 100ps
// Checker for the sample mixer: predicts every mixed sample and compares it with the output beats.
module mix_checker
    import mvsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         command,
    input  logic [4:0]         voice,
    input  logic [31:0]        trigger_mask,
    input  logic [11:0]        sample_address,
    input  logic signed [15:0] sample_value,
    input  logic [12:0]        length,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] mixed_sample,
    output int                 pending,
    output int                 fails
);
    logic signed [15:0] wave_mem [WAVE_DEPTH];
    logic [LEN_W-1:0]   len_of [VOICES];
    logic [ADDR_W-1:0]  cursor_of [VOICES];
    logic               playing [VOICES];
    logic [3:0]         gain;
    logic               fx_on;
    logic signed [15:0] expected_mix [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fails++;
    endtask

    // One tick of the mixer: visits voices in order, saturating after each.
    function automatic logic signed [15:0] mix_next_tick();
        int acc;
        int pos;
        int s;
        bit oneshot;
        acc = 0;
        for (int i = 0; i < VOICES; i++)
        begin
            oneshot = (i < ONESHOT_VOICES);
            pos = cursor_of[i];
            if (len_of[i] == 0)
                continue;
            if (!playing[i] && (pos == 0 || !oneshot))
                continue;
            if (pos >= len_of[i])
                pos = 0;
            s = wave_mem[i * SAMPLES_PER_VOICE + pos];
            acc = acc + (s * int'(gain)) / 10;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            pos++;
            if (pos >= len_of[i])
            begin
                pos = 0;
                if (oneshot)
                    playing[i] = 1'b0;
            end
            cursor_of[i] = pos[ADDR_W-1:0];
        end
        return acc[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                len_of[i] = '0;
                cursor_of[i] = '0;
                playing[i] = 1'b0;
            end
            gain = VOLUME_RESET;
            fx_on = 1'b1;
            expected_mix.delete();
            pending = 0;
            fails = fails;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VOLUME)
                    gain = (cfg_data > VOLUME_MAX) ? VOLUME_MAX : cfg_data;
                else
                    fx_on = cfg_data[0];
            end
            if (in_valid && in_ready)
            begin
                case (command)
                    CMD_TICK:
                        expected_mix.push_back(mix_next_tick());
                    CMD_TRIGGER:
                        if (gain != 0 && fx_on)
                            for (int i = 0; i < VOICES; i++)
                            begin
                                if (trigger_mask[i])
                                begin
                                    playing[i] = 1'b1;
                                    if (i < ONESHOT_VOICES)
                                        cursor_of[i] = '0;
                                end
                                else if (i >= ONESHOT_VOICES)
                                    playing[i] = 1'b0;
                            end
                    CMD_HALT:
                        for (int i = 0; i < VOICES; i++)
                            playing[i] = 1'b0;
                    CMD_STOP:
                        for (int i = 0; i < VOICES; i++)
                        begin
                            playing[i] = 1'b0;
                            cursor_of[i] = '0;
                        end
                    CMD_WRITE:
                        wave_mem[voice * SAMPLES_PER_VOICE + sample_address] = sample_value;
                    CMD_LENGTH:
                    begin
                        len_of[voice] = (length > SAMPLES_PER_VOICE) ?
                                        LEN_W'(SAMPLES_PER_VOICE) : length;
                        cursor_of[voice] = '0;
                        playing[voice] = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_mix.size() == 0)
                    report_mismatch($sformatf("unexpected sample %0d", mixed_sample));
                else
                begin
                    want = expected_mix.pop_front();
                    if (mixed_sample !== want)
                        report_mismatch($sformatf("mixed_sample %0d, expected %0d",
                                                  mixed_sample, want));
                end
            end
            pending = expected_mix.size();
        end
    end

    initial fails = 0;
endmodule

/* tb/multi_voice_sample_mixer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the sample mixer: drives commands and register writes, gives the verdict.
module multi_voice_sample_mixer_top_tb;
    import mvsm_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         command;
    logic [4:0]         voice;
    logic [31:0]        trigger_mask;
    logic [11:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [12:0]        length;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] mixed_sample;
    int                 pending;
    int                 fails;

    // Percent chance per cycle that the sender or the receiver holds off.
    int send_idle_pct;
    int recv_idle_pct;

    // Length of the contiguous written prefix of each voice's waveform.
    // Bar the directed clamp case, a voice is only given a length it has
    // samples for, so the mixer never reads a waveform entry never written.
    int written_upto [VOICES];

    localparam int TICK_CYCLES = 4 * VOICES + 4;

    multi_voice_sample_mixer_top uut (.*);

    mix_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random, re-rolled on every falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Drives one command beat and waits until the mixer takes it. Valid only
    // drops when the sender decides to idle, never within the same step as
    // the next raise.
    task automatic send_cmd(input logic [2:0] cmd, input int v, input logic [31:0] mask,
                            input int addr, input int val, input int len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        voice          <= v[4:0];
        trigger_mask   <= mask;
        sample_address <= addr[11:0];
        sample_value   <= val[15:0];
        length         <= len[12:0];
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_sample(input int v, input int addr, input int val);
        send_cmd(CMD_WRITE, v, $urandom, addr, val, $urandom);
        if (addr == written_upto[v])
            written_upto[v]++;
    endtask

    // Fills any missing waveform entries first, then sets the length.
    task automatic load_length(input int v, input int len);
        int need;
        need = (len > SAMPLES_PER_VOICE) ? SAMPLES_PER_VOICE : len;
        while (written_upto[v] < need)
            write_sample(v, written_upto[v], $urandom);
        send_cmd(CMD_LENGTH, v, $urandom, $urandom, $urandom, len);
    endtask

    // Registers change only with the mixer quiet: all samples back, plus a
    // further wait in case the last command had no result.
    task automatic write_reg(input logic idx, input logic [3:0] data);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TICK_CYCLES + 20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_beat();
        int pick;
        int v;
        int len;
        pick = $urandom_range(99);
        v = $urandom_range(VOICES - 1);
        if (pick < 40)
            send_cmd(CMD_TICK, v, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 55)
            send_cmd(CMD_TRIGGER, v, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 59)
            send_cmd(CMD_HALT, v, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 62)
            send_cmd(CMD_STOP, v, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 82)
            write_sample(v, $urandom_range(SAMPLES_PER_VOICE - 1), $urandom);
        else if (pick < 95)
        begin
            // Short waveforms, now and then an unloaded voice.
            if ($urandom_range(9) == 0)
                len = 0;
            else
                len = $urandom_range(1, 12);
            load_length(v, len);
        end
        else
            send_cmd(3'($urandom_range(6, 7)), v, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_VOLUME;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_TICK;
        voice = '0;
        trigger_mask = '0;
        sample_address = '0;
        sample_value = '0;
        length = '0;
        out_ready = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 65;
        foreach (written_upto[i])
            written_upto[i] = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: full-scale samples on one-shot and looping voices,
        // so that the running sum saturates at full gain.
        write_reg(REG_VOLUME, VOLUME_MAX);
        write_sample(0, 0, 32767);
        write_sample(0, 1, -32768);
        load_length(0, 2);
        write_sample(1, 0, 32767);
        load_length(1, 1);
        write_sample(18, 0, -1);
        write_sample(18, 1, 1);
        load_length(18, 2);
        write_sample(19, 0, 32767);
        load_length(19, 1);
        write_sample(20, 0, -32768);
        load_length(20, 1);
        // The last voice gets an oversized length that clamps. Only a short
        // prefix is written: it plays for a few ticks before it is shortened.
        for (int a = 0; a < 8; a++)
            write_sample(VOICES - 1, a, $urandom);
        send_cmd(CMD_LENGTH, VOICES - 1, 0, 0, 0, 8191);
        // Triggering every voice flags unloaded ones too; they must stay silent.
        send_cmd(CMD_TRIGGER, 0, 32'hFFFF_FFFF, 0, 0, 0);
        repeat (3) send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        // After a halt a one-shot voice mid-pass still finishes its pass.
        send_cmd(CMD_TRIGGER, 0, 32'h0000_0001, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        send_cmd(CMD_HALT, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        send_cmd(CMD_TRIGGER, 0, 32'h8010_0003, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        send_cmd(CMD_STOP, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        send_cmd(3'd6, 0, 0, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0, 0, 0);
        // A trigger with effects off is ignored.
        write_reg(REG_EFFECTS, 4'd0);
        send_cmd(CMD_TRIGGER, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        write_reg(REG_EFFECTS, 4'd1);
        // Zero gain ignores triggers and mixes silence.
        write_reg(REG_VOLUME, 4'd0);
        send_cmd(CMD_TRIGGER, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        // The last voice goes back to a length within its written prefix.
        load_length(VOICES - 1, 4);

        // Random part in three idling phases, each with a few register settings;
        // 15 is written to check the clamp to full gain.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < 4; k++)
            begin
                case (k)
                    0: write_reg(REG_VOLUME, 4'd15);
                    1: write_reg(REG_VOLUME, 4'($urandom_range(1, 9)));
                    2: write_reg(REG_EFFECTS, 4'($urandom_range(1)));
                    default:
                    begin
                        write_reg(REG_EFFECTS, 4'd1);
                        write_reg(REG_VOLUME, VOLUME_RESET);
                    end
                endcase
                repeat (35) random_beat();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TICK_CYCLES + 20) @(negedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
